>>> sv/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
package gha_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 1024;
  localparam int unsigned GEN_W          = 32;
  localparam int unsigned HIDX_W         = 32;
  localparam int unsigned ADDR_W         = 16;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_UNUSED   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [HIDX_W-1:0] handle_index;
    logic [GEN_W-1:0]  handle_generation;
  } gha_req_t;

  typedef struct packed {
    logic [HIDX_W-1:0] out_index;
    logic [GEN_W-1:0]  out_generation;
    logic              is_valid;
    logic [1:0]        status;
  } gha_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] gen_rd_addr;
    logic              gen_we;
    logic [ADDR_W-1:0] gen_wr_addr;
    logic [GEN_W-1:0]  gen_wdata;
    logic [ADDR_W-1:0] stk_rd_addr;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_wr_addr;
    logic [ADDR_W-1:0] stk_wdata;
  } gha_mem_req_t;

endpackage

>>> sv/generational_handle_allocator.sv
// Top level: sequencer of the generational handle allocator.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | gha_req_t in_req
//   out_    | output    | out_valid / out_stall | gha_res_t out_res
//
// One request at a time; in_stall is high from acceptance until its result is registered.
// States after acceptance: DECODE then DONE for allocate of a fresh slot, errors, out-of-range check and unknown kind;
// an in-range check passes CHK, a valid free INC, allocate from the free stack POP and LOAD, before DONE.
// out_stall only holds the result register; the next request is taken once it is loaded.
// Reset clears the counters; memory contents are not cleared and need no sweep.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gha_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output gha_res_t out_res
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_POP, S_LOAD, S_CHK, S_INC, S_DONE
  } state_t;

  typedef enum logic [1:0] {ALU_LT, ALU_EQ, ALU_INC} alu_op_t;

  state_t            state_r, state_nxt;
  gha_req_t          req_r, req_nxt;
  gha_res_t          res_r, res_nxt;
  gha_res_t          out_res_r, out_res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  hw_r, hw_nxt;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]  fc_dec;

  gha_mem_req_t      mem_req;
  logic [GEN_W-1:0]  gen_rdata;
  logic [IDX_W-1:0]  stk_rdata;

  alu_op_t           alu_op;
  logic [GEN_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_flag;

  gha_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .gen_rdata (gen_rdata),
    .stk_rdata (stk_rdata)
  );

  // shared compare / increment unit
  always_comb begin
    alu_sum  = '0;
    alu_flag = 1'b0;
    unique case (alu_op)
      ALU_LT:  alu_flag = (alu_a < alu_b);
      ALU_EQ:  alu_flag = (alu_a == alu_b);
      ALU_INC: alu_sum  = alu_a + alu_b;
      default: alu_flag = 1'b0;
    endcase
  end

  assign fc_dec = fc_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    hw_nxt        = hw_r;
    fc_nxt        = fc_r;
    slot_nxt      = slot_r;
    mem_req       = '0;
    alu_op        = ALU_LT;
    alu_a         = req_r.handle_index;
    alu_b         = GEN_W'(hw_r);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        mem_req.gen_rd_addr = ADDR_W'(req_r.handle_index[IDX_W-1:0]);
        unique case (req_r.kind)
          KIND_ALLOC: begin
            if (fc_r != '0) begin
              mem_req.stk_rd_addr = ADDR_W'(fc_dec[IDX_W-1:0]);
              fc_nxt    = fc_dec;
              state_nxt = S_POP;
            end else if (hw_r != CNT_W'(SLOT_COUNT)) begin
              mem_req.gen_we      = 1'b1;
              mem_req.gen_wr_addr = ADDR_W'(hw_r[IDX_W-1:0]);
              mem_req.gen_wdata   = GEN_W'(1);
              res_nxt.out_index      = HIDX_W'(hw_r);
              res_nxt.out_generation = GEN_W'(1);
              hw_nxt = hw_r + CNT_W'(1);
            end else begin
              res_nxt.status = ST_FULL;
            end
          end
          KIND_CHECK: begin
            if (alu_flag) begin
              state_nxt = S_CHK;
            end
          end
          KIND_FREE: begin
            if (!alu_flag) begin
              res_nxt.status = ST_UNUSED;
            end else if (fc_r == CNT_W'(SLOT_COUNT)) begin
              res_nxt.status = ST_OVERFLOW;
            end else begin
              state_nxt = S_INC;
            end
          end
          default: res_nxt = '0;
        endcase
      end
      S_POP: begin
        slot_nxt = stk_rdata;
        mem_req.gen_rd_addr = ADDR_W'(stk_rdata);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        res_nxt.out_index      = HIDX_W'(slot_r);
        res_nxt.out_generation = gen_rdata;
        state_nxt = S_DONE;
      end
      S_CHK: begin
        alu_op = ALU_EQ;
        alu_a  = gen_rdata;
        alu_b  = req_r.handle_generation;
        res_nxt.is_valid = alu_flag;
        state_nxt = S_DONE;
      end
      S_INC: begin
        alu_op = ALU_INC;
        alu_a  = gen_rdata;
        alu_b  = GEN_W'(1);
        mem_req.gen_we      = 1'b1;
        mem_req.gen_wr_addr = ADDR_W'(req_r.handle_index[IDX_W-1:0]);
        mem_req.gen_wdata   = alu_sum;
        mem_req.stk_we      = 1'b1;
        mem_req.stk_wr_addr = ADDR_W'(fc_r[IDX_W-1:0]);
        mem_req.stk_wdata   = ADDR_W'(req_r.handle_index[IDX_W-1:0]);
        fc_nxt    = fc_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hw_r        <= '0;
      fc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hw_r        <= hw_nxt;
      fc_r        <= fc_nxt;
    end
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    slot_r    <= slot_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CNT_W'(SLOT_COUNT)) else $error("high-water count beyond capacity");

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CNT_W'(SLOT_COUNT)) else $error("free stack depth beyond capacity");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.is_valid |-> out_res_r.status == ST_OK)
    else $error("valid check with error status");

  a_index_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.out_index != '0) |-> out_res_r.out_index < HIDX_W'(hw_r))
    else $error("allocated index above high-water mark");

endmodule

>>> sv/gha_store.sv
// Generation table and free stack memories with registered read data.
module gha_store
  import gha_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk,
  input  gha_mem_req_t     mem_req,
  output logic [GEN_W-1:0] gen_rdata,
  output logic [IDX_W-1:0] stk_rdata
);

  logic [GEN_W-1:0] gen_mem [SLOT_COUNT];
  logic [IDX_W-1:0] stk_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (mem_req.gen_we) begin
      gen_mem[mem_req.gen_wr_addr[IDX_W-1:0]] <= mem_req.gen_wdata;
    end
    gen_rdata <= gen_mem[mem_req.gen_rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mem_req.stk_we) begin
      stk_mem[mem_req.stk_wr_addr[IDX_W-1:0]] <= mem_req.stk_wdata[IDX_W-1:0];
    end
    stk_rdata <= stk_mem[mem_req.stk_rd_addr[IDX_W-1:0]];
  end

endmodule
